// ----- rtl/ocd_pkg.sv -----
// ----------------------------------------------------------------------------
// ocd_pkg: shared types and constants of the ohmmeter display block
// Widths, divider cell beat type, reciprocal constants and digit patterns.
// ----------------------------------------------------------------------------
package ocd_pkg;

  localparam int unsigned CodeW = 10;
  localparam int unsigned RefW  = 17;
  localparam int unsigned DvdW  = RefW + CodeW;
  localparam int unsigned DsrW  = CodeW + 1;
  localparam int unsigned ResW  = 24;
  localparam int unsigned SegW  = 8;
  localparam int unsigned ColW  = 3;

  localparam logic [RefW-1:0] RefReset = 17'd980;
  localparam logic [DsrW-1:0] CodeSpan = 11'd1024;

  localparam logic [ResW-1:0] ResMax   = 24'hFFFFFF;
  localparam logic [ResW-1:0] Lim100k  = 24'd100000;
  localparam logic [ResW-1:0] Lim10k   = 24'd10000;
  localparam logic [ResW-1:0] LimShort = 24'd20;

  // floor(x/1000) = (x*Rcp1000)>>27 for x < 100000
  localparam logic [17:0] Rcp1000 = 18'd134218;
  // floor(x/100) = (x*Rcp100)>>20 for x < 10000
  localparam logic [13:0] Rcp100  = 14'd10486;
  // floor(x/10) = (x*Rcp10)>>11 for x < 100
  localparam logic [7:0]  Rcp10   = 8'd205;

  localparam logic [SegW-1:0] SegDash = 8'hBF;
  localparam logic [SegW-1:0] DpOff   = 8'h80;
  localparam logic [ColW-1:0] ColMax  = 3'd7;

  typedef struct packed {
    logic            valid;
    logic [DsrW-1:0] rem;
    logic [DvdW-1:0] dvd;
    logic [DvdW-1:0] quo;
    logic [DsrW-1:0] dsr;
  } div_beat_t;

  function automatic logic [SegW-1:0] seg_pattern(input logic [3:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h40;
      4'd1:    seg = 8'h79;
      4'd2:    seg = 8'h24;
      4'd3:    seg = 8'h30;
      4'd4:    seg = 8'h19;
      4'd5:    seg = 8'h12;
      4'd6:    seg = 8'h02;
      4'd7:    seg = 8'h78;
      4'd8:    seg = 8'h00;
      4'd9:    seg = 8'h10;
      default: seg = SegDash;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/ocd_cell.sv -----
// ----------------------------------------------------------------------------
// ocd_cell: one restoring division cell
// Produces one quotient bit per beat and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module ocd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ocd_pkg::div_beat_t  beat_in,
  output ocd_pkg::div_beat_t  beat_out
);

  logic [ocd_pkg::DsrW:0]   trial;
  logic [ocd_pkg::DsrW:0]   diff;
  logic                     take;
  ocd_pkg::div_beat_t       beat_nxt;
  ocd_pkg::div_beat_t       beat_r;

  always_comb begin
    trial = {beat_in.rem, beat_in.dvd[ocd_pkg::DvdW-1]};
    diff  = trial - {1'b0, beat_in.dsr};
    take  = (trial >= {1'b0, beat_in.dsr});
    beat_nxt       = beat_in;
    beat_nxt.rem   = take ? diff[ocd_pkg::DsrW-1:0] : trial[ocd_pkg::DsrW-1:0];
    beat_nxt.dvd   = {beat_in.dvd[ocd_pkg::DvdW-2:0], 1'b0};
    beat_nxt.quo   = {beat_in.quo[ocd_pkg::DvdW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r.valid <= beat_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r.rem <= beat_nxt.rem;
      beat_r.dvd <= beat_nxt.dvd;
      beat_r.quo <= beat_nxt.quo;
      beat_r.dsr <= beat_nxt.dsr;
    end
  end

  assign beat_out = beat_r;

endmodule

// ----- rtl/ocd_display.sv -----
// ----------------------------------------------------------------------------
// ocd_display: saturation, digit split and segment decode
// Two stages: range flags and reciprocal digits, then patterns and colour.
// ----------------------------------------------------------------------------
module ocd_display (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        quo_valid,
  input  logic [ocd_pkg::DvdW-1:0]    quo,
  output logic                        out_valid,
  output logic [ocd_pkg::ResW-1:0]    out_resistance_ohms,
  output logic [ocd_pkg::SegW-1:0]    out_upper_segments,
  output logic [ocd_pkg::SegW-1:0]    out_lower_segments,
  output logic [ocd_pkg::ColW-1:0]    out_range_colour,
  output logic                        out_short_alarm
);

  // stage a
  logic                      sat;
  logic [ocd_pkg::ResW-1:0]  res_nxt;
  logic [34:0]               kilo_full;
  logic [27:0]               hecto_full;
  logic                      a_valid_r;
  logic [ocd_pkg::ResW-1:0]  res_r;
  logic [6:0]                kilo_r;
  logic [6:0]                hecto_r;
  logic                      lt10k_r;
  logic                      lt100k_r;
  logic                      lt20_r;

  // stage b
  logic [14:0]               tens_full;
  logic [3:0]                tens;
  logic [6:0]                lo_kilo;
  logic [6:0]                lo_hecto;
  logic [ocd_pkg::SegW-1:0]  up_nxt;
  logic [ocd_pkg::SegW-1:0]  lo_nxt;
  logic [ocd_pkg::ColW-1:0]  col_nxt;
  logic                      valid_r;
  logic [ocd_pkg::ResW-1:0]  res_o_r;
  logic [ocd_pkg::SegW-1:0]  up_r;
  logic [ocd_pkg::SegW-1:0]  lo_r;
  logic [ocd_pkg::ColW-1:0]  col_r;
  logic                      short_r;

  always_comb begin
    sat        = |quo[ocd_pkg::DvdW-1:ocd_pkg::ResW];
    res_nxt    = sat ? ocd_pkg::ResMax : quo[ocd_pkg::ResW-1:0];
    kilo_full  = 35'(quo[16:0]) * 35'(ocd_pkg::Rcp1000);
    hecto_full = 28'(quo[13:0]) * 28'(ocd_pkg::Rcp100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r    <= res_nxt;
      kilo_r   <= kilo_full[33:27];
      hecto_r  <= hecto_full[26:20];
      lt100k_r <= (res_nxt < ocd_pkg::Lim100k);
      lt10k_r  <= (res_nxt < ocd_pkg::Lim10k);
      lt20_r   <= (res_nxt < ocd_pkg::LimShort);
    end
  end

  always_comb begin
    tens_full = 15'(kilo_r) * 15'(ocd_pkg::Rcp10);
    tens      = tens_full[14:11];
    lo_kilo   = kilo_r - 7'(tens) * 7'd10;
    lo_hecto  = hecto_r - kilo_r * 7'd10;
    if (lt10k_r) begin
      up_nxt  = ocd_pkg::seg_pattern(kilo_r[3:0]);
      lo_nxt  = ocd_pkg::seg_pattern(lo_hecto[3:0]);
      col_nxt = '0;
    end else if (lt100k_r) begin
      up_nxt  = ocd_pkg::seg_pattern(tens);
      lo_nxt  = ocd_pkg::seg_pattern(lo_kilo[3:0]) | ocd_pkg::DpOff;
      col_nxt = (tens > 4'd7) ? ocd_pkg::ColMax : tens[2:0];
    end else begin
      up_nxt  = ocd_pkg::SegDash;
      lo_nxt  = ocd_pkg::SegDash;
      col_nxt = ocd_pkg::ColMax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_o_r <= res_r;
      up_r    <= up_nxt;
      lo_r    <= lo_nxt;
      col_r   <= col_nxt;
      short_r <= lt20_r;
    end
  end

  assign out_valid           = valid_r;
  assign out_resistance_ohms = res_o_r;
  assign out_upper_segments  = up_r;
  assign out_lower_segments  = lo_r;
  assign out_range_colour    = col_r;
  assign out_short_alarm     = short_r;

endmodule

// ----- rtl/ohmmeter_code_to_display.sv -----
// ----------------------------------------------------------------------------
// ohmmeter_code_to_display: adc code to resistance and two-digit display
// Stages: multiply stage, 27 division cells, two display stages.
// Throughput one beat per cycle; the whole pipeline holds while the output
// register is full and stalled. Synchronous active-low reset empties the
// pipeline and loads the reference register with 980 ohms.
// ----------------------------------------------------------------------------
module ohmmeter_code_to_display (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ocd_pkg::RefW-1:0]    cfg_ref_resistor_ohms,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ocd_pkg::CodeW-1:0]   in_adc_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ocd_pkg::ResW-1:0]    out_resistance_ohms,
  output logic [ocd_pkg::SegW-1:0]    out_upper_segments,
  output logic [ocd_pkg::SegW-1:0]    out_lower_segments,
  output logic [ocd_pkg::ColW-1:0]    out_range_colour,
  output logic                        out_short_alarm
);

  logic                       adv;
  logic [ocd_pkg::RefW-1:0]   ref_r;
  ocd_pkg::div_beat_t         head_nxt;
  ocd_pkg::div_beat_t         head_r;
  ocd_pkg::div_beat_t         chain [ocd_pkg::DvdW+1];

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= ocd_pkg::RefReset;
    end else if (cfg_valid && cfg_ready) begin
      ref_r <= cfg_ref_resistor_ohms;
    end
  end

  always_comb begin
    head_nxt.valid = in_valid;
    head_nxt.rem   = '0;
    head_nxt.dvd   = {{ocd_pkg::CodeW{1'b0}}, ref_r} *
                     {{ocd_pkg::RefW{1'b0}}, in_adc_code};
    head_nxt.quo   = '0;
    head_nxt.dsr   = ocd_pkg::CodeSpan - {1'b0, in_adc_code};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (adv) begin
      head_r.valid <= head_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head_r.rem <= head_nxt.rem;
      head_r.dvd <= head_nxt.dvd;
      head_r.quo <= head_nxt.quo;
      head_r.dsr <= head_nxt.dsr;
    end
  end

  assign chain[0] = head_r;

  for (genvar i = 0; i < ocd_pkg::DvdW; i++) begin : g_cell
    ocd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  ocd_display u_display (
    .clk                 (clk),
    .rst_n               (rst_n),
    .en                  (adv),
    .quo_valid           (chain[ocd_pkg::DvdW].valid),
    .quo                 (chain[ocd_pkg::DvdW].quo),
    .out_valid           (out_valid),
    .out_resistance_ohms (out_resistance_ohms),
    .out_upper_segments  (out_upper_segments),
    .out_lower_segments  (out_lower_segments),
    .out_range_colour    (out_range_colour),
    .out_short_alarm     (out_short_alarm)
  );

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of ohmmeter_code_to_display
// Sends ADC codes across several reference resistor settings, predicts the
// resistance and display of each code, and checks every result beat in
// order. Both sides idle and stall at random, with one long output hold.
// ----------------------------------------------------------------------------
module tb;
  import ocd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned HoldAfter  = 600;
  localparam int unsigned PhaseItems = 146;

  typedef struct packed {
    logic [ResW-1:0] ohms;
    logic [SegW-1:0] upper_seg;
    logic [SegW-1:0] lower_seg;
    logic [ColW-1:0] colour;
    logic            alarm;
  } reading_t;

  class reading_board;
    logic [RefW-1:0] series_ohms;
    reading_t        expected_readings[$];
    int              errors;

    function new();
      series_ohms = RefReset;
      errors = 0;
    endfunction

    function void set_series(logic [RefW-1:0] ohms);
      series_ohms = ohms;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function logic [SegW-1:0] digit_pattern(int unsigned digit);
      logic [SegW-1:0] seg;
      case (digit)
        0: seg = 8'h40;
        1: seg = 8'h79;
        2: seg = 8'h24;
        3: seg = 8'h30;
        4: seg = 8'h19;
        5: seg = 8'h12;
        6: seg = 8'h02;
        7: seg = 8'h78;
        8: seg = 8'h00;
        default: seg = 8'h10;
      endcase
      return seg;
    endfunction

    function void note_code(logic [CodeW-1:0] code);
      logic [63:0] quotient;
      int unsigned ohms;
      int unsigned tens_k;
      reading_t r;
      quotient = (64'(series_ohms) * 64'(code)) / (64'd1024 - 64'(code));
      ohms = (quotient > 64'(ResMax)) ? 32'(ResMax) : 32'(quotient);
      r.ohms = ohms[ResW-1:0];
      r.alarm = (ohms < 20);
      tens_k = ohms / 10000;
      if (ohms < 10000) begin
        r.upper_seg = digit_pattern(ohms / 1000);
        r.lower_seg = digit_pattern((ohms / 100) % 10);
        r.colour = '0;
      end else if (ohms < 100000) begin
        r.upper_seg = digit_pattern(tens_k);
        r.lower_seg = digit_pattern((ohms / 1000) % 10) | DpOff;
        r.colour = (tens_k > 7) ? ColMax : ColW'(tens_k);
      end else begin
        r.upper_seg = SegDash;
        r.lower_seg = SegDash;
        r.colour = ColMax;
      end
      expected_readings.push_back(r);
    endfunction

    function void check(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("unexpected beat: resistance_ohms %0d", got.ohms);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.ohms !== want.ohms) begin
        $error("resistance_ohms expected %0d actual %0d", want.ohms, got.ohms);
        errors++;
      end
      if (got.upper_seg !== want.upper_seg) begin
        $error("upper_segments expected %h actual %h", want.upper_seg, got.upper_seg);
        errors++;
      end
      if (got.lower_seg !== want.lower_seg) begin
        $error("lower_segments expected %h actual %h", want.lower_seg, got.lower_seg);
        errors++;
      end
      if (got.colour !== want.colour) begin
        $error("range_colour expected %0d actual %0d", want.colour, got.colour);
        errors++;
      end
      if (got.alarm !== want.alarm) begin
        $error("short_alarm expected %0d actual %0d", want.alarm, got.alarm);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [RefW-1:0]  cfg_ref_resistor_ohms = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CodeW-1:0] in_adc_code = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ResW-1:0]  out_resistance_ohms;
  logic [SegW-1:0]  out_upper_segments;
  logic [SegW-1:0]  out_lower_segments;
  logic [ColW-1:0]  out_range_colour;
  logic             out_short_alarm;

  reading_board board = new();
  reading_t     seen_reading;
  int unsigned  codes_sent = 0;
  int unsigned  cycles = 0;
  int unsigned  hold_left = 0;
  logic         hold_done = 1'b0;

  ohmmeter_code_to_display dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_ref_resistor_ohms (cfg_ref_resistor_ohms),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_adc_code           (in_adc_code),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_resistance_ohms   (out_resistance_ohms),
    .out_upper_segments    (out_upper_segments),
    .out_lower_segments    (out_lower_segments),
    .out_range_colour      (out_range_colour),
    .out_short_alarm       (out_short_alarm)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // no idling on either side over a stretch of codes
  function automatic logic idle_now();
    if (codes_sent >= 200 && codes_sent < 350) return 1'b0;
    return ($urandom_range(99) < 18);
  endfunction

  function automatic logic [CodeW-1:0] random_code();
    case ($urandom_range(3))
      0: return CodeW'($urandom_range(1023, 880));
      1: return CodeW'($urandom_range(40));
      default: return CodeW'($urandom_range(1023));
    endcase
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("ohmmeter_code_to_display: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && codes_sent >= HoldAfter) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_stall <= idle_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_series(cfg_ref_resistor_ohms);
      if (in_valid && !in_stall) board.note_code(in_adc_code);
      if (out_valid && !out_stall) begin
        seen_reading.ohms = out_resistance_ohms;
        seen_reading.upper_seg = out_upper_segments;
        seen_reading.lower_seg = out_lower_segments;
        seen_reading.colour = out_range_colour;
        seen_reading.alarm = out_short_alarm;
        board.check(seen_reading);
      end
    end
  end

  task automatic send_code(input logic [CodeW-1:0] code);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    codes_sent++;
  endtask

  task automatic write_series(input logic [RefW-1:0] ohms);
    cfg_valid <= 1'b1;
    cfg_ref_resistor_ohms <= ohms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [CodeW-1:0] opening_codes [14];
    logic [RefW-1:0]  series_list [8];
    opening_codes = '{10'd0, 10'd1, 10'd20, 10'd21, 10'd511, 10'd512, 10'd932,
                      10'd933, 10'd1014, 10'd1015, 10'd1022, 10'd1023,
                      10'h155, 10'h2AA};
    series_list[0] = '0;
    series_list[1] = 17'd1;
    series_list[2] = 17'd131071;
    series_list[3] = 17'd1000;
    series_list[4] = RefW'($urandom_range(131071, 1));
    series_list[5] = RefW'($urandom_range(131071, 1));
    series_list[6] = RefW'($urandom_range(20000, 1));
    series_list[7] = RefReset;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_codes[i]) send_code(opening_codes[i]);
    repeat (PhaseItems) send_code(random_code());
    drain();

    foreach (series_list[p]) begin
      write_series(series_list[p]);
      send_code('0);
      send_code(10'd1);
      send_code(10'd1022);
      send_code(10'd1023);
      repeat (PhaseItems) send_code(random_code());
      drain();
    end

    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ohmmeter_code_to_display: match");
    end else begin
      $display("ohmmeter_code_to_display: mismatch");
    end
    $finish;
  end

endmodule
